FILE: src/cmam_pkg.sv
// ----------------------------------------------------------------------------
// cmam_pkg
// Shared types and constants of the masked centered moving average block.
// ----------------------------------------------------------------------------
package cmam_pkg;

	localparam int SAMPLE_W       = 32;
	localparam int WIN_W          = 5;
	localparam int MAX_WINDOW_DEF = 31;
	localparam int PASS_MIN       = 2;
	localparam int APB_W          = 32;
	localparam int ADDR_W         = 3;

	localparam logic [WIN_W-1:0] WIN_RESET  = 5'd3;
	localparam logic             REG_WINDOW = 1'b0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLASSIFY,
		ST_CHECK,
		ST_DUMP_RD,
		ST_DUMP_OUT,
		ST_MEAN_INIT,
		ST_MEAN_RUN,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_MEAN_OUT
	} cmam_state_t;

	typedef enum logic [1:0] {
		OSEL_RAW_IN,
		OSEL_RAW_RING,
		OSEL_MEAN
	} cmam_osel_t;

	typedef struct packed {
		logic       take_in;
		logic       ring_wr;
		logic       end_stream;
		logic       dump_rd;
		logic       mean_init;
		logic       mean_run;
		logic       div_start;
		logic       load_out;
		cmam_osel_t out_sel;
	} cmam_cmd_t;

	typedef struct packed {
		logic pass;
		logic last;
		logic short_str;
		logic more;
		logic pend_nz;
		logic out_free;
		logic cnt_zero;
		logic mean_done;
		logic div_busy;
	} cmam_sts_t;

endpackage

FILE: src/cmam_div.sv
// ----------------------------------------------------------------------------
// cmam_div
// Restoring signed-by-unsigned divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module cmam_div
	import cmam_pkg::*;
#(
	parameter int NUM_W = 37,
	parameter int DEN_W = 5
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] num,
	input  logic        [DEN_W-1:0] den,
	output logic                    busy,
	output logic signed [NUM_W-1:0] quot
);

	localparam int STEP_W = $clog2(NUM_W + 1);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [DEN_W-1:0]  rem_q;
	logic [NUM_W-1:0]  quo_q;
	logic [DEN_W-1:0]  den_q;
	logic              neg_q;
	logic [DEN_W:0]    trial;
	logic              fits;
	logic [NUM_W-1:0]  num_mag;

	always_comb begin
		trial   = {rem_q, quo_q[NUM_W-1]};
		fits    = trial >= {1'b0, den_q};
		num_mag = num[NUM_W-1] ? $unsigned(-num) : $unsigned(num);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(NUM_W);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == STEP_W'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num_mag;
			den_q <= den;
			neg_q <= num[NUM_W-1];
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quot = neg_q ? $signed(-quo_q) : $signed(quo_q);

endmodule

FILE: src/cmam_dp.sv
// ----------------------------------------------------------------------------
// cmam_dp
// Datapath: sample ring, stream pointers, window sum and count, divider and
// result register.
// ----------------------------------------------------------------------------
module cmam_dp
	import cmam_pkg::*;
#(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [WIN_W-1:0]           cfg_window,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       is_outlier,
	input  logic                       last_sample,
	input  cmam_cmd_t                  cmd,
	output cmam_sts_t                  sts,
	input  logic                       out_stall,
	output logic                       out_valid,
	output logic signed [SAMPLE_W-1:0] average,
	output logic                       no_valid,
	output logic                       last_result
);

	localparam int DEPTH = MAX_WINDOW + 1;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int SUM_W = SAMPLE_W + IDX_W;
	localparam int L_W   = (IDX_W > WIN_W) ? IDX_W : WIN_W;
	localparam int ENT_W = SAMPLE_W + 1;

	localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W + 1)'(DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

	function automatic logic [IDX_W-1:0] inc_ptr(input logic [IDX_W-1:0] p);
		return (p == LAST_IDX) ? '0 : p + 1'b1;
	endfunction

	logic [ENT_W-1:0]    ring [DEPTH];
	logic [ENT_W-1:0]    ram_q;

	logic [SAMPLE_W-1:0] smp_q;
	logic                outl_q;
	logic                last_q;
	logic [WIN_W-1:0]    win_q;
	logic [WIN_W-1:0]    pos_q;
	logic [WIN_W-1:0]    nout_q;
	logic [IDX_W-1:0]    wr_q;
	logic [IDX_W-1:0]    rd_q;
	logic [IDX_W-1:0]    addr_q;
	logic [IDX_W-1:0]    left_q;
	logic                rdv_s1;
	logic signed [SUM_W-1:0] sum_q;
	logic [IDX_W-1:0]    cnt_q;

	logic                out_valid_q;
	logic [SAMPLE_W-1:0] average_q;
	logic                no_valid_q;
	logic                last_result_q;

	logic [WIN_W-1:0]    win_clip;
	logic [IDX_W:0]      pend_wide;
	logic [IDX_W-1:0]    pend;
	logic [WIN_W-1:0]    w2;
	logic [L_W-1:0]      pend_l;
	logic [L_W-1:0]      w2_l;
	logic [L_W-1:0]      nout_l;
	logic [L_W-1:0]      ahead_l;
	logic [L_W-1:0]      back_l;
	logic [L_W-1:0]      fwd_l;
	logic [IDX_W-1:0]    back_i;
	logic [IDX_W-1:0]    span;
	logic [IDX_W:0]      start_wide;
	logic [IDX_W-1:0]    start;
	logic                ring_re;
	logic [IDX_W-1:0]    ring_ra;
	logic                out_free;
	logic                cnt_zero;
	logic                div_busy;
	logic signed [SUM_W-1:0] quot;

	always_comb begin
		win_clip  = (int'(cfg_window) > MAX_WINDOW) ? WIN_W'(MAX_WINDOW) : cfg_window;
		pend_wide = (wr_q >= rd_q) ? {1'b0, wr_q} - {1'b0, rd_q}
		                           : {1'b0, wr_q} + DEPTH_X - {1'b0, rd_q};
		pend      = pend_wide[IDX_W-1:0];
		w2        = win_q >> 1;
		pend_l    = L_W'(pend);
		w2_l      = L_W'(w2);
		nout_l    = L_W'(nout_q);
		ahead_l   = pend_l - 1'b1;
		back_l    = (nout_l < w2_l) ? nout_l : w2_l;
		fwd_l     = (ahead_l < w2_l) ? ahead_l : w2_l;
		back_i    = IDX_W'(back_l);
		span      = IDX_W'(back_l + fwd_l + 1'b1);
		start_wide = (rd_q >= back_i) ? {1'b0, rd_q} - {1'b0, back_i}
		                              : {1'b0, rd_q} + DEPTH_X - {1'b0, back_i};
		start     = start_wide[IDX_W-1:0];
		ring_re   = cmd.dump_rd || (cmd.mean_run && left_q != '0);
		ring_ra   = cmd.dump_rd ? rd_q : addr_q;
		out_free  = !out_valid_q || !out_stall;
		cnt_zero  = cnt_q == '0;
	end

	always_comb begin
		sts.pass      = win_q < WIN_W'(PASS_MIN);
		sts.last      = last_q;
		sts.short_str = pos_q < win_q;
		sts.more      = last_q ? (pend != '0) : (pend_l > w2_l);
		sts.pend_nz   = pend != '0;
		sts.out_free  = out_free;
		sts.cnt_zero  = cnt_zero;
		sts.mean_done = (left_q == '0) && !rdv_s1;
		sts.div_busy  = div_busy;
	end

	cmam_div #(
		.NUM_W (SUM_W),
		.DEN_W (IDX_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start && !cnt_zero),
		.num    (sum_q),
		.den    (cnt_q),
		.busy   (div_busy),
		.quot   (quot)
	);

	always_ff @(posedge clk) begin
		if (cmd.ring_wr)
			ring[wr_q] <= {outl_q, smp_q};
		if (ring_re)
			ram_q <= ring[ring_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q       <= '0;
			pos_q       <= '0;
			nout_q      <= '0;
			wr_q        <= '0;
			rd_q        <= '0;
			left_q      <= '0;
			rdv_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.take_in && pos_q == '0)
				win_q <= win_clip;
			if (cmd.ring_wr) begin
				wr_q <= inc_ptr(wr_q);
				if (pos_q < win_q)
					pos_q <= pos_q + 1'b1;
			end
			rdv_s1 <= cmd.mean_run && left_q != '0;
			if (cmd.mean_init)
				left_q <= span;
			else if (cmd.mean_run && left_q != '0)
				left_q <= left_q - 1'b1;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
				if (cmd.out_sel != OSEL_RAW_IN)
					rd_q <= inc_ptr(rd_q);
				if (cmd.out_sel == OSEL_MEAN && nout_q != '1)
					nout_q <= nout_q + 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.end_stream) begin
				pos_q  <= '0;
				nout_q <= '0;
				wr_q   <= '0;
				rd_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			smp_q  <= sample;
			outl_q <= is_outlier;
			last_q <= last_sample;
		end
		if (cmd.mean_init) begin
			addr_q <= start;
			sum_q  <= '0;
			cnt_q  <= '0;
		end else begin
			if (cmd.mean_run && left_q != '0)
				addr_q <= inc_ptr(addr_q);
			if (rdv_s1 && !ram_q[SAMPLE_W]) begin
				sum_q <= sum_q + SUM_W'($signed(ram_q[SAMPLE_W-1:0]));
				cnt_q <= cnt_q + 1'b1;
			end
		end
		if (cmd.load_out) begin
			unique case (cmd.out_sel)
				OSEL_RAW_IN: begin
					average_q     <= smp_q;
					no_valid_q    <= 1'b0;
					last_result_q <= last_q;
				end
				OSEL_RAW_RING: begin
					average_q     <= ram_q[SAMPLE_W-1:0];
					no_valid_q    <= 1'b0;
					last_result_q <= pend == IDX_W'(1);
				end
				OSEL_MEAN: begin
					average_q     <= cnt_zero ? '0 : quot[SAMPLE_W-1:0];
					no_valid_q    <= cnt_zero;
					last_result_q <= last_q && pend == IDX_W'(1);
				end
				default: begin
					average_q     <= smp_q;
					no_valid_q    <= 1'b0;
					last_result_q <= last_q;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign average     = $signed(average_q);
	assign no_valid    = no_valid_q;
	assign last_result = last_result_q;

	a_pos_within_window: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= win_q)
		else $error("stream position passed the window");

	a_pending_within_window: assert property (@(posedge clk) disable iff (!arst_n)
		win_q >= WIN_W'(PASS_MIN) |-> pend_l <= L_W'(win_q))
		else $error("ring holds more samples than the window");

	a_load_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> out_free)
		else $error("result loaded over an untaken beat");

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start && !cnt_zero |-> !div_busy)
		else $error("divider restarted while busy");

endmodule

FILE: src/cmam_ctrl.sv
// ----------------------------------------------------------------------------
// cmam_ctrl
// Controller: sequences intake, pass-through output, ring write, raw dump
// and the per-result window scan and divide.
// ----------------------------------------------------------------------------
module cmam_ctrl
	import cmam_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  cmam_sts_t sts,
	output cmam_cmd_t cmd
);

	cmam_state_t state_q;
	cmam_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.out_sel = OSEL_RAW_IN;
		in_stall    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.take_in = 1'b1;
					state_d     = ST_CLASSIFY;
				end
			end
			ST_CLASSIFY: begin
				if (sts.pass) begin
					if (sts.out_free) begin
						cmd.load_out   = 1'b1;
						cmd.out_sel    = OSEL_RAW_IN;
						cmd.end_stream = sts.last;
						state_d        = ST_IDLE;
					end
				end else begin
					cmd.ring_wr = 1'b1;
					state_d     = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.short_str) begin
					if (sts.last && sts.pend_nz) begin
						state_d = ST_DUMP_RD;
					end else begin
						cmd.end_stream = sts.last;
						state_d        = ST_IDLE;
					end
				end else if (sts.more) begin
					state_d = ST_MEAN_INIT;
				end else begin
					cmd.end_stream = sts.last;
					state_d        = ST_IDLE;
				end
			end
			ST_DUMP_RD: begin
				cmd.dump_rd = 1'b1;
				state_d     = ST_DUMP_OUT;
			end
			ST_DUMP_OUT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					cmd.out_sel  = OSEL_RAW_RING;
					state_d      = ST_CHECK;
				end
			end
			ST_MEAN_INIT: begin
				cmd.mean_init = 1'b1;
				state_d       = ST_MEAN_RUN;
			end
			ST_MEAN_RUN: begin
				cmd.mean_run = 1'b1;
				if (sts.mean_done)
					state_d = ST_DIV_START;
			end
			ST_DIV_START: begin
				cmd.div_start = 1'b1;
				state_d       = sts.cnt_zero ? ST_MEAN_OUT : ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (!sts.div_busy)
					state_d = ST_MEAN_OUT;
			end
			ST_MEAN_OUT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					cmd.out_sel  = OSEL_MEAN;
					state_d      = ST_CHECK;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: src/centered_moving_average_masked.sv
// ----------------------------------------------------------------------------
// centered_moving_average_masked
// Centered moving average over a sample stream, outliers masked out.
// ----------------------------------------------------------------------------
// Input beats carry sample, is_outlier and last_sample; output beats carry
// average, no_valid and last_result. Both channels move a beat when valid is
// high and stall is low. The window length is written over the APB port at
// address 0 (reset 3) and is taken at the first beat of each stream.
// One input beat is worked on at a time; in_stall is high from acceptance
// until all of its results are in the output register.
// Pass-through (window below 2): one result per beat.
// Filling a stream: a beat gives no result.
// Each mean result: scan of the span (up to 2*(window/2)+1 samples) through
// the one read port of the sample ring, then the divider at one quotient bit
// per cycle. A short stream's raw dump reads each result from the ring and
// outputs it before the next check. Results lag the input by half a window
// and leave in bursts.
// A stalled output beat holds in the output register; the next result waits
// behind it. Reset clears the controller, the stream pointers and the window
// register; the sample ring is not cleared.
// ----------------------------------------------------------------------------
module centered_moving_average_masked
	import cmam_pkg::*;
#(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ADDR_W-1:0]          paddr,
	input  logic [APB_W-1:0]           pwdata,
	output logic [APB_W-1:0]           prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       is_outlier,
	input  logic                       last_sample,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] average,
	output logic                       no_valid,
	output logic                       last_result
);

	logic [WIN_W-1:0] window_q;
	logic             reg_hit;
	cmam_cmd_t        cmd;
	cmam_sts_t        sts;

	assign reg_hit = paddr[ADDR_W-1] == REG_WINDOW;
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? APB_W'(window_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			window_q <= WIN_RESET;
		else if (psel && penable && pwrite && pready && reg_hit)
			window_q <= pwdata[WIN_W-1:0];
	end

	cmam_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	cmam_dp #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_window  (window_q),
		.sample      (sample),
		.is_outlier  (is_outlier),
		.last_sample (last_sample),
		.cmd         (cmd),
		.sts         (sts),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.average     (average),
		.no_valid    (no_valid),
		.last_result (last_result)
	);

endmodule
